FILE: design/clqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqm_pkg: shared codes and control types for the lock queue manager
// Request kinds, lock state codes, callback kinds and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package clqm_pkg;

  // request kinds
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // lock state codes (code 3 is unused)
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_LOCKED  = 2'd1;
  localparam logic [1:0] ST_WAITING = 2'd2;

  // answer to the requester
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RETRY = 1'b1;

  // callback kinds
  localparam logic [1:0] NK_NONE   = 2'd0;
  localparam logic [1:0] NK_REVOKE = 2'd1;
  localparam logic [1:0] NK_RETRY  = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic clr_step;  // clear one lock table entry
    logic accept;    // capture request word, read lock entry
    logic load;      // lock entry ready, read queue head
    logic head;      // head word ready, start membership scan
    logic scan;      // compare one queued word
    logic commit;    // write back and present the result
  } ctrl_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic clr_last;   // last entry of the clearing pass
    logic need_scan;  // queue membership must be searched
    logic scan_done;  // membership search finished
  } ctrl_sts_t;

endpackage

FILE: design/clqm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqm_ctrl: sequencing state machine
// Runs the table clearing pass after reset, then steps each request through
// entry read, head read, optional queue scan and write-back.
// ----------------------------------------------------------------------------
module clqm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output clqm_pkg::ctrl_cmd_t cmd,
  input  clqm_pkg::ctrl_sts_t sts
);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_LRD  = 6'b000100,
    S_HEAD = 6'b001000,
    S_SCAN = 6'b010000,
    S_WR   = 6'b100000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: if (start) state_nxt = S_LRD;
      S_LRD:  state_nxt = S_HEAD;
      S_HEAD: state_nxt = sts.need_scan ? S_SCAN : S_WR;
      S_SCAN: if (sts.scan_done) state_nxt = S_WR;
      S_WR:   state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  always_comb begin
    cmd.clr_step = (state_r == S_CLR);
    cmd.accept   = (state_r == S_IDLE) && start;
    cmd.load     = (state_r == S_LRD);
    cmd.head     = (state_r == S_HEAD);
    cmd.scan     = (state_r == S_SCAN);
    cmd.commit   = (state_r == S_WR);
  end

  assign busy = (state_r != S_IDLE);

  // checks
  a_accept_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_LRD))
    else $error("accepted word did not move to entry load");

  a_load_to_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LRD) |=> (state_r == S_HEAD))
    else $error("entry load not followed by head stage");

  a_commit_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !busy)
    else $error("controller still busy after write-back");

endmodule

FILE: design/clqm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqm_datapath: lock table, wait queue store and request decision
// Lock table holds state, holder and queue pointers per lock; the wait store
// holds the queued client ids, QUEUE_DEPTH words per lock.
// ----------------------------------------------------------------------------
module clqm_datapath #(
  parameter int NUM_LOCKS      = 16,
  parameter int QUEUE_DEPTH    = 8,
  parameter int CLIENT_ID_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  clqm_pkg::ctrl_cmd_t cmd,
  output clqm_pkg::ctrl_sts_t sts,
  input  logic                in_op,
  input  logic [3:0]          in_lock_index,
  input  logic [7:0]          in_client_id,
  output logic                out_valid,
  output logic                out_status,
  output logic [1:0]          out_notify_kind,
  output logic [7:0]          out_notify_client,
  output logic                out_queue_full
);

  localparam int LkW   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int QpW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int IdW   = CLIENT_ID_BITS;
  localparam int WqN   = NUM_LOCKS * QUEUE_DEPTH;
  localparam int AddrW = (WqN > 1) ? $clog2(WqN) : 1;

  typedef struct packed {
    logic [1:0]      st;
    logic            hv;
    logic [IdW-1:0]  hc;
    logic [QpW-1:0]  head;
    logic [CntW-1:0] cnt;
  } lock_ent_t;

  // queue position wrap: s is below twice the depth
  function automatic logic [QpW-1:0] wrap_pos(input logic [QpW-1:0] base,
                                              input logic [CntW-1:0] off);
    logic [CntW:0] s;
    s = (CntW+1)'(base) + (CntW+1)'(off);
    if (s >= (CntW+1)'(QUEUE_DEPTH)) begin
      s = s - (CntW+1)'(QUEUE_DEPTH);
    end
    return QpW'(s);
  endfunction

  function automatic logic [AddrW-1:0] slot_addr(input logic [LkW-1:0] lk,
                                                 input logic [QpW-1:0] pos);
    return AddrW'(AddrW'(lk) * AddrW'(QUEUE_DEPTH)) + AddrW'(pos);
  endfunction

  // storage
  lock_ent_t      lock_mem [NUM_LOCKS];
  logic [IdW-1:0] wait_mem [WqN];

  lock_ent_t      lk_rd_r;
  logic [IdW-1:0] wq_rd_r;

  // request word and scan registers
  logic            op_r;
  logic [LkW-1:0]  lk_r;
  logic            lk_ok_r;
  logic [IdW-1:0]  id_r;
  logic [IdW-1:0]  hd_r;
  logic            found_r;
  logic [CntW-1:0] rd_off_r;
  logic [CntW-1:0] cmp_off_r;
  logic [LkW-1:0]  clr_idx_r;

  // output registers
  logic            out_valid_r;
  logic            status_r, status_nxt;
  logic [1:0]      nk_r, nk_nxt;
  logic [IdW-1:0]  nc_r, nc_nxt;
  logic            qfull_r, qfull_nxt;

  lock_ent_t       ent_nxt;
  logic            enq;
  logic            wq_full;
  logic            is_head;
  logic            hit;
  logic [CntW-1:0] rd_off;
  logic [AddrW-1:0] wq_raddr;
  logic [AddrW-1:0] wq_waddr;

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_step) begin
      clr_idx_r <= clr_idx_r + LkW'(1);
    end
  end

  // lock table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      lock_mem[clr_idx_r] <= '0;
    end else if (cmd.commit && lk_ok_r) begin
      lock_mem[lk_r] <= ent_nxt;
    end
    if (cmd.accept) begin
      lk_rd_r <= lock_mem[LkW'(in_lock_index)];
    end
  end

  // request word capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_op;
      lk_r    <= LkW'(in_lock_index);
      lk_ok_r <= ({7'd0, in_lock_index} < 11'(NUM_LOCKS));
      id_r    <= IdW'(in_client_id);
    end
  end

  // wait store read: head on load, then successive offsets
  assign rd_off   = cmd.load ? '0 : rd_off_r;
  assign wq_raddr = slot_addr(lk_r, wrap_pos(lk_rd_r.head, rd_off));
  assign wq_waddr = slot_addr(lk_r, wrap_pos(lk_rd_r.head, lk_rd_r.cnt));

  always_ff @(posedge clk) begin
    if (cmd.commit && enq && !wq_full) begin
      wait_mem[wq_waddr] <= id_r;
    end
    if (cmd.load || cmd.head || cmd.scan) begin
      wq_rd_r <= wait_mem[wq_raddr];
    end
  end

  // scan offsets and membership flag
  assign hit = (wq_rd_r == id_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_off_r <= CntW'(1);
    end else if (cmd.head || cmd.scan) begin
      rd_off_r <= rd_off_r + CntW'(1);
    end
    if (cmd.head) begin
      hd_r      <= wq_rd_r;
      cmp_off_r <= CntW'(1);
      found_r   <= 1'b0;
    end else if (cmd.scan) begin
      cmp_off_r <= cmp_off_r + CntW'(1);
      found_r   <= found_r | hit;
    end
  end

  // status to the controller
  always_comb begin
    sts.clr_last  = (clr_idx_r == LkW'(NUM_LOCKS - 1));
    sts.need_scan = lk_ok_r && (op_r == clqm_pkg::OP_ACQUIRE) &&
                    (lk_rd_r.st == clqm_pkg::ST_WAITING) &&
                    !hit && (lk_rd_r.cnt > CntW'(1));
    sts.scan_done = hit || (cmp_off_r == lk_rd_r.cnt - CntW'(1));
  end

  // request decision
  assign is_head = (lk_rd_r.cnt != '0) && (hd_r == id_r);
  assign wq_full = (lk_rd_r.cnt == CntW'(QUEUE_DEPTH));

  always_comb begin
    ent_nxt    = lk_rd_r;
    status_nxt = clqm_pkg::STATUS_OK;
    nk_nxt     = clqm_pkg::NK_NONE;
    nc_nxt     = '0;
    qfull_nxt  = 1'b0;
    enq        = 1'b0;
    if (lk_ok_r) begin
      if (op_r == clqm_pkg::OP_ACQUIRE) begin
        unique case (lk_rd_r.st)
          clqm_pkg::ST_FREE: begin
            ent_nxt.st = clqm_pkg::ST_LOCKED;
            ent_nxt.hv = 1'b1;
            ent_nxt.hc = id_r;
          end
          clqm_pkg::ST_LOCKED: begin
            ent_nxt.st = clqm_pkg::ST_WAITING;
            enq        = 1'b1;
            status_nxt = clqm_pkg::STATUS_RETRY;
            if (lk_rd_r.hv) begin
              nk_nxt = clqm_pkg::NK_REVOKE;
              nc_nxt = lk_rd_r.hc;
            end
          end
          clqm_pkg::ST_WAITING: begin
            if (is_head) begin
              ent_nxt.hv   = 1'b1;
              ent_nxt.hc   = id_r;
              ent_nxt.head = wrap_pos(lk_rd_r.head, CntW'(1));
              ent_nxt.cnt  = lk_rd_r.cnt - CntW'(1);
              if (lk_rd_r.cnt == CntW'(1)) begin
                ent_nxt.st = clqm_pkg::ST_LOCKED;
              end else begin
                nk_nxt = clqm_pkg::NK_REVOKE;
                nc_nxt = id_r;
              end
            end else begin
              status_nxt = clqm_pkg::STATUS_RETRY;
              enq        = !found_r;
            end
          end
          default: begin
            // unused code: no change
          end
        endcase
        // queue insert, dropped when full
        if (enq) begin
          if (wq_full) begin
            qfull_nxt = 1'b1;
          end else begin
            ent_nxt.cnt = lk_rd_r.cnt + CntW'(1);
          end
        end
      end else if (lk_rd_r.hv && (lk_rd_r.hc == id_r)) begin
        if (lk_rd_r.st == clqm_pkg::ST_LOCKED) begin
          ent_nxt.st = clqm_pkg::ST_FREE;
          ent_nxt.hv = 1'b0;
        end else if (lk_rd_r.st == clqm_pkg::ST_WAITING) begin
          ent_nxt.hv = 1'b0;
          if (lk_rd_r.cnt != '0) begin
            nk_nxt = clqm_pkg::NK_RETRY;
            nc_nxt = hd_r;
          end
        end
      end
    end
  end

  // result word registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      nk_r     <= nk_nxt;
      nc_r     <= nc_nxt;
      qfull_r  <= qfull_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_notify_kind   = nk_r;
  assign out_notify_client = 8'(nc_r);
  assign out_queue_full    = qfull_r;

  // checks
  a_one_word_per_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_full_means_retry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && qfull_r) |-> (status_r == clqm_pkg::STATUS_RETRY))
    else $error("queue full flagged on a granted request");

  a_scan_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (lk_rd_r.st == clqm_pkg::ST_WAITING))
    else $error("queue scan on a lock that is not waiting");

endmodule

FILE: design/cached_lock_queue_manager_core.sv
`timescale 1ns / 1ps
// Sequence: request capture with lock entry read, queue head read, search of
//   the queued words on a waiting lock (up to QUEUE_DEPTH-1), then write-back and the registered result.
// Throughput: a new request is taken only after write-back; the lock table
//   read-modify-write and the one-word-a-cycle queue search set it.
// Reset: busy stays high while the lock table is cleared.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// cached_lock_queue_manager_core: lock table with per-lock wait queues
// Grants, queues, revokes and retries lock requests, one result per request.
// ----------------------------------------------------------------------------
module cached_lock_queue_manager_core #(
  parameter int NUM_LOCKS      = 16,
  parameter int QUEUE_DEPTH    = 8,
  parameter int CLIENT_ID_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_op,
  input  logic [3:0] in_lock_index,
  input  logic [7:0] in_client_id,
  output logic       out_valid,
  output logic       out_status,
  output logic [1:0] out_notify_kind,
  output logic [7:0] out_notify_client,
  output logic       out_queue_full
);

  clqm_pkg::ctrl_cmd_t cmd;
  clqm_pkg::ctrl_sts_t sts;

  // sequencer
  clqm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // lock table and queues
  clqm_datapath #(
    .NUM_LOCKS      (NUM_LOCKS),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .CLIENT_ID_BITS (CLIENT_ID_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_lock_index     (in_lock_index),
    .in_client_id      (in_client_id),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_notify_kind   (out_notify_kind),
    .out_notify_client (out_notify_client),
    .out_queue_full    (out_queue_full)
  );

endmodule

FILE: verif/cached_lock_queue_manager_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cached_lock_queue_manager_core_test: self-checking bench for the lock core
// Drives acquire and release words through the start/busy handshake, runs a
// shadow lock table alongside the core and compares every result word with
// the answer the shadow table gives. Some random words are steered towards
// current holders and queue heads so that grants, revokes, retries and full
// queues all come up often.
// ----------------------------------------------------------------------------
module cached_lock_queue_manager_core_test;

  localparam int NLOCKS      = 16;
  localparam int WAIT_DEPTH  = 8;
  localparam int RAND_WORDS  = 1800;
  localparam int POOL_SIZE   = 12;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic       op;
    logic [3:0] lk;
    logic [7:0] id;
  } lock_request_t;

  typedef struct packed {
    logic       status;
    logic [1:0] nk;
    logic [7:0] nc;
    logic       full;
  } lock_answer_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_op = clqm_pkg::OP_ACQUIRE;
  logic [3:0] in_lock_index = 4'd0;
  logic [7:0] in_client_id = 8'd0;
  logic       out_valid;
  logic       out_status;
  logic [1:0] out_notify_kind;
  logic [7:0] out_notify_client;
  logic       out_queue_full;

  // shadow lock table
  logic [1:0] lk_state [NLOCKS];
  logic       hold_valid [NLOCKS];
  logic [7:0] hold_id [NLOCKS];
  logic [7:0] waiters [NLOCKS][WAIT_DEPTH];
  logic [2:0] wq_head [NLOCKS];
  logic [3:0] wq_count [NLOCKS];

  lock_request_t pending [$];
  lock_answer_t  answers [$];
  logic [7:0]    pool [POOL_SIZE];
  bit            word_taken = 1'b0;
  int            sent = 0;
  int            errors = 0;
  int            cycles = 0;

  cached_lock_queue_manager_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_lock_index(in_lock_index),
    .in_client_id(in_client_id),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_notify_kind(out_notify_kind),
    .out_notify_client(out_notify_client),
    .out_queue_full(out_queue_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic lock_request_t req(logic op, logic [3:0] lk, logic [7:0] id);
    lock_request_t r;
    r.op = op;
    r.lk = lk;
    r.id = id;
    return r;
  endfunction

  // append to a lock's wait queue; returns 1 when the word is dropped
  function automatic logic push_waiter(logic [3:0] lk, logic [7:0] id);
    if (wq_count[lk] >= 4'(WAIT_DEPTH)) return 1'b1;
    waiters[lk][wq_head[lk] + wq_count[lk][2:0]] = id;
    wq_count[lk] = wq_count[lk] + 4'd1;
    return 1'b0;
  endfunction

  // apply one request to the shadow table and return the answer it gives
  function automatic lock_answer_t serve_request(logic op, logic [3:0] lk, logic [7:0] id);
    lock_answer_t a;
    logic         found;
    a = '0;
    found = 1'b0;
    if (op == clqm_pkg::OP_ACQUIRE) begin
      unique case (lk_state[lk])
        clqm_pkg::ST_FREE: begin
          lk_state[lk] = clqm_pkg::ST_LOCKED;
          hold_valid[lk] = 1'b1;
          hold_id[lk] = id;
        end
        clqm_pkg::ST_LOCKED: begin
          // queued with no membership check, even the holder itself
          lk_state[lk] = clqm_pkg::ST_WAITING;
          a.full = push_waiter(lk, id);
          a.status = clqm_pkg::STATUS_RETRY;
          if (hold_valid[lk]) begin
            a.nk = clqm_pkg::NK_REVOKE;
            a.nc = hold_id[lk];
          end
        end
        clqm_pkg::ST_WAITING: begin
          if (wq_count[lk] != 4'd0 && waiters[lk][wq_head[lk]] == id) begin
            hold_valid[lk] = 1'b1;
            hold_id[lk] = id;
            wq_head[lk] = wq_head[lk] + 3'd1;
            wq_count[lk] = wq_count[lk] - 4'd1;
            if (wq_count[lk] == 4'd0) begin
              lk_state[lk] = clqm_pkg::ST_LOCKED;
            end else begin
              a.nk = clqm_pkg::NK_REVOKE;
              a.nc = id;
            end
          end else begin
            a.status = clqm_pkg::STATUS_RETRY;
            for (int i = 0; i < int'(wq_count[lk]); i++)
              if (waiters[lk][wq_head[lk] + 3'(i)] == id) found = 1'b1;
            if (!found) a.full = push_waiter(lk, id);
          end
        end
        default: ;
      endcase
    end else if (hold_valid[lk] && hold_id[lk] == id) begin
      if (lk_state[lk] == clqm_pkg::ST_LOCKED) begin
        lk_state[lk] = clqm_pkg::ST_FREE;
        hold_valid[lk] = 1'b0;
      end else if (lk_state[lk] == clqm_pkg::ST_WAITING) begin
        hold_valid[lk] = 1'b0;
        if (wq_count[lk] != 4'd0) begin
          a.nk = clqm_pkg::NK_RETRY;
          a.nc = waiters[lk][wq_head[lk]];
        end
      end
    end
    return a;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // result check first, then prediction of the word taken at this edge
  always @(posedge clk) begin
    lock_answer_t want;
    word_taken = rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (answers.size() == 0) begin
        $error("result word with nothing outstanding");
        errors++;
      end else begin
        want = answers.pop_front();
        check_field("status", int'(want.status), int'(out_status));
        check_field("notify_kind", int'(want.nk), int'(out_notify_kind));
        check_field("notify_client", int'(want.nc), int'(out_notify_client));
        check_field("queue_full", int'(want.full), int'(out_queue_full));
      end
    end
    if (word_taken)
      answers.push_back(serve_request(in_op, in_lock_index, in_client_id));
  end

  // driver: present a new word once the previous one is taken
  always @(negedge clk) begin
    lock_request_t r;
    bit            gap;
    gap = (sent < 800 || sent >= 1200) && ($urandom_range(99) < 15);
    if (!start || word_taken) begin
      if (rst_n && pending.size() != 0 && !gap) begin
        r = pending.pop_front();
        in_op <= r.op;
        in_lock_index <= r.lk;
        in_client_id <= r.id;
        start <= 1'b1;
        sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int         kind;
    logic [3:0] hot;
    logic [7:0] who;
    for (int l = 0; l < NLOCKS; l++) begin
      lk_state[l] = clqm_pkg::ST_FREE;
      hold_valid[l] = 1'b0;
      hold_id[l] = 8'd0;
      wq_head[l] = 3'd0;
      wq_count[l] = 4'd0;
      for (int k = 0; k < WAIT_DEPTH; k++) waiters[l][k] = 8'd0;
    end
    for (int k = 0; k < POOL_SIZE; k++) pool[k] = 8'($urandom_range(255));

    // directed: grant, revoke, duplicate waiter, stray releases, head takeover
    pending.push_back(req(clqm_pkg::OP_ACQUIRE, 4'd0, 8'h00));
    pending.push_back(req(clqm_pkg::OP_ACQUIRE, 4'd0, 8'hFF));
    pending.push_back(req(clqm_pkg::OP_ACQUIRE, 4'd0, 8'h11));
    pending.push_back(req(clqm_pkg::OP_ACQUIRE, 4'd0, 8'h11));
    pending.push_back(req(clqm_pkg::OP_RELEASE, 4'd0, 8'h22));
    pending.push_back(req(clqm_pkg::OP_RELEASE, 4'd0, 8'h00));
    pending.push_back(req(clqm_pkg::OP_RELEASE, 4'd0, 8'h00));
    pending.push_back(req(clqm_pkg::OP_ACQUIRE, 4'd0, 8'hFF));
    pending.push_back(req(clqm_pkg::OP_ACQUIRE, 4'd0, 8'h11));
    // holder queues behind itself while locked
    pending.push_back(req(clqm_pkg::OP_ACQUIRE, 4'd0, 8'h11));
    pending.push_back(req(clqm_pkg::OP_RELEASE, 4'd0, 8'h11));
    pending.push_back(req(clqm_pkg::OP_ACQUIRE, 4'd0, 8'h11));
    pending.push_back(req(clqm_pkg::OP_RELEASE, 4'd0, 8'h11));
    // fill the top lock's queue until an enqueue is dropped
    pending.push_back(req(clqm_pkg::OP_ACQUIRE, 4'd15, 8'h80));
    for (int k = 1; k <= 9; k++)
      pending.push_back(req(clqm_pkg::OP_ACQUIRE, 4'd15, 8'(k)));
    pending.push_back(req(clqm_pkg::OP_RELEASE, 4'd15, 8'h80));

    // random words, some steered by the shadow table
    for (int n = 0; n < RAND_WORDS; n++) begin
      while (pending.size() >= 2) @(negedge clk);
      kind = $urandom_range(99);
      hot = 4'($urandom_range(3));
      who = pool[$urandom_range(POOL_SIZE - 1)];
      if (kind < 30) begin
        pending.push_back(req(clqm_pkg::OP_ACQUIRE, hot, who));
      end else if (kind < 45) begin
        pending.push_back(req(clqm_pkg::OP_RELEASE, hot,
                              hold_valid[hot] ? hold_id[hot] : who));
      end else if (kind < 60) begin
        pending.push_back(req(clqm_pkg::OP_ACQUIRE, hot,
                              wq_count[hot] != 4'd0 ? waiters[hot][wq_head[hot]] : who));
      end else if (kind < 70) begin
        pending.push_back(req(clqm_pkg::OP_RELEASE, hot, who));
      end else if (kind < 80) begin
        pending.push_back(req(1'($urandom_range(1)), 4'($urandom_range(15)),
                              8'($urandom_range(255))));
      end else begin
        pending.push_back(req(clqm_pkg::OP_ACQUIRE, 4'($urandom_range(15)), who));
      end
    end

    // drain, then allow for a stray late result
    while (pending.size() != 0 || start || answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
